// ===== hdl/bms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and constants of the bounded multiset store.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_COUNT  = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic sample;  // latch compare result against the incoming value
    logic shift;   // take left neighbor's entry (insert at the head)
    logic pull;    // take right neighbor's entry where found (remove)
  } cell_ctrl_t;

endpackage

// ===== hdl/bms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_cell
// One slot of the store: holds an entry, compares it, moves with neighbors.
// ----------------------------------------------------------------------------
module bms_cell
  import bms_pkg::*;
(
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      used_i,
  input  logic signed [VALUE_W-1:0] left_i,
  input  logic signed [VALUE_W-1:0] right_i,
  input  logic                      found_i,
  output logic signed [VALUE_W-1:0] entry_o,
  output logic                      match_o,
  output logic                      found_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      match_q, match_d;

  // found so far along the chain, this cell included
  assign found_o = found_i | match_q;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    if (ctrl_i.sample) begin
      match_d = used_i && (entry_q == value_i);
    end
    if (ctrl_i.shift) begin
      entry_d = left_i;
    end else if (ctrl_i.pull && found_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== hdl/bounded_multiset_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_multiset_store_top
// Bounded multiset of signed 32-bit values held in a row of entry cells.
// ----------------------------------------------------------------------------
// each operation has an accept cycle, where every cell compares its entry with
// the value, and an evaluate cycle, where the match count is formed and the row
// shifts or compacts; busy_o is high for the evaluate cycle only, and no new
// beat is accepted while it is high. the result appears in the cycle after the
// evaluate cycle, on valid_o for exactly one cycle, and must be taken then
// since there is no back-pressure. entries stay packed in cells
// 0 .. count-1: insert pushes the value in at cell 0, remove closes the gap
// left by the first matching entry. a full table ignores inserts, op code 3
// only reports. counts wider than five bits are wrapped to five.
// ----------------------------------------------------------------------------
module bounded_multiset_store_top
  import bms_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      valid_o,
  output logic [CNT_W-1:0]          occurrences_o,
  output logic                      done_res_o,
  output logic [CNT_W-1:0]          stored_count_o
);

  // wide enough to hold the capacity itself
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [OP_W-1:0]           op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CW-1:0]             fill_q, fill_d;

  logic                      valid_q, valid_d;
  logic [CNT_W-1:0]          occ_q, occ_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          stored_q, stored_d;

  logic                      accept;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]       cell_match;
  logic [CAPACITY-1:0]       cell_found;

  logic                      has_room;
  logic                      any_found;
  logic [CW-1:0]             occ_cnt;
  logic [CW+CNT_W-1:0]       occ_ext, fill_ext;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign has_room  = fill_q < CW'(CAPACITY);
  assign any_found = cell_found[CAPACITY-1];
  // occurrences are taken from the compare bits latched at accept
  assign occ_cnt   = CW'($countones(cell_match));

  // ---- the row of cells ----------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left, right;
    logic                      found_in;
    if (i == 0) begin : g_head
      assign left     = value_q;
      assign found_in = 1'b0;
    end else begin : g_body
      assign left     = cell_entry[i-1];
      assign found_in = cell_found[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = cell_entry[i];
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    bms_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .used_i  (CW'(i) < fill_q),
      .left_i  (left),
      .right_i (right),
      .found_i (found_in),
      .entry_o (cell_entry[i]),
      .match_o (cell_match[i]),
      .found_o (cell_found[i])
    );
  end

  // ---- sequencer -----------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    valid_d     = 1'b0;
    occ_d       = occ_q;
    done_d      = done_q;
    stored_d    = stored_q;
    ctrl        = '0;
    ctrl.sample = accept;
    occ_ext     = {{CNT_W{1'b0}}, occ_cnt};
    fill_ext    = {{CNT_W{1'b0}}, fill_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        done_d  = 1'b0;
        case (op_e'(op_q))
          OP_INSERT: begin
            if (has_room) begin
              ctrl.shift = 1'b1;
              fill_d     = fill_q + CW'(1);
              done_d     = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (any_found) begin
              ctrl.pull = 1'b1;
              fill_d    = fill_q - CW'(1);
              done_d    = 1'b1;
            end
          end
          OP_COUNT: begin
            done_d = 1'b1;
          end
          default: begin
            // unused code: report only
            done_d = 1'b0;
          end
        endcase
        fill_ext = {{CNT_W{1'b0}}, fill_d};
        occ_d    = occ_ext[CNT_W-1:0];
        stored_d = fill_ext[CNT_W-1:0];
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  // payload of the beat and of the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    occ_q    <= occ_d;
    done_q   <= done_d;
    stored_q <= stored_d;
  end

  assign busy_o         = (state_q == ST_EVAL);
  assign valid_o        = valid_q;
  assign occurrences_o  = occ_q;
  assign done_res_o     = done_q;
  assign stored_count_o = stored_q;

`ifndef SYNTHESIS
  // an accepted beat is evaluated next cycle and reported the one after
  a_accept_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o ##1 valid_o)
    else $error("accepted beat did not produce a result two cycles later");

  // the fill count never passes the capacity
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // the fill count only moves in the evaluate cycle, by one at most
  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> $stable(fill_q))
    else $error("fill count changed outside evaluation");

  // a successful remove needs an occurrence
  a_remove_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && op_q == OP_REMOVE && occ_cnt == '0) |=> !done_res_o)
    else $error("remove reported success without a matching entry");
`endif

endmodule

// ===== test/bounded_multiset_store_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_multiset_store_top_test
// Self-checking bench for the bounded multiset store.
// ----------------------------------------------------------------------------
// a short table of directed beats runs first. it covers the empty table, the
// extreme values, every op code including the unused one, a full table and
// a remove of an absent value. random beats follow in blocks: some blocks lean
// to inserts and fill the table, some lean to removes and drain it. the sender
// idles at random, with one stretch of blocks that never idles, and now and
// then it waits until every result is back. a bag model in the bench predicts
// each result. a monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_multiset_store_top_test;
  import bms_pkg::*;

  localparam int unsigned BAG_CAP     = CAPACITY_DEF;
  localparam int          CYCLE_LIMIT = 200_000;
  // op code 3 is left unused by the package; the block treats it as a no-op
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] occ;
    logic             done;
    logic [CNT_W-1:0] stored;
  } bag_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               typed;  // res holds the expected result as typed in
    bag_result_t        res;
  } dir_row_t;

  // directed beats, in order, starting from an empty table
  localparam int DIR_ROWS_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{OP_COUNT,  32'h0000_0000, 1'b1, '{5'd0,  1'b1, 5'd0}},   // count on empty
    '{OP_REMOVE, 32'h0000_0005, 1'b1, '{5'd0,  1'b0, 5'd0}},   // remove from empty
    '{OP_NOP,    32'h0000_0000, 1'b1, '{5'd0,  1'b0, 5'd0}},   // unused op code
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{5'd0,  1'b1, 5'd1}},   // most negative
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, '{5'd0,  1'b1, 5'd2}},   // most positive
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{5'd0,  1'b1, 5'd3}},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, '{5'd0,  1'b1, 5'd4}},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, '{5'd1,  1'b1, 5'd5}},   // duplicate
    '{OP_COUNT,  32'hffff_ffff, 1'b1, '{5'd2,  1'b1, 5'd5}},
    '{OP_REMOVE, 32'h8000_0000, 1'b1, '{5'd1,  1'b1, 5'd4}},
    '{OP_COUNT,  32'h8000_0000, 1'b1, '{5'd0,  1'b1, 5'd4}},
    '{OP_NOP,    32'hffff_ffff, 1'b1, '{5'd2,  1'b0, 5'd4}},   // no-op still counts
    // fill up to capacity, predicted
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b0, '0},
    '{OP_INSERT, 32'h5a5a_5a5a, 1'b1, '{5'd12, 1'b0, 5'd16}}   // full table
  };

  logic                      clk_i   = 1'b0;
  logic                      rst_ni  = 1'b0;
  logic                      start_i = 1'b0;
  logic [OP_W-1:0]           op_i    = OP_INSERT;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      busy_o;
  logic                      valid_o;
  logic [CNT_W-1:0]          occurrences_o;
  logic                      done_res_o;
  logic [CNT_W-1:0]          stored_count_o;

  // bag model: unordered values below bag_fill
  logic [VALUE_W-1:0] bag_vals [BAG_CAP];
  int                 bag_fill = 0;

  bag_result_t pending_results [$];
  int          n_errors   = 0;
  int          idle_pct   = 0;
  int          n_by_op [4] = '{0, 0, 0, 0};
  int          n_full_ins = 0;
  int          n_miss_rem = 0;

  bounded_multiset_store_top #(
    .CAPACITY(BAG_CAP)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .occurrences_o (occurrences_o),
    .done_res_o    (done_res_o),
    .stored_count_o(stored_count_o)
  );

  always #2 clk_i = ~clk_i;

  // apply one operation to the bag model and return what the block must report
  function automatic bag_result_t bag_apply(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
    bag_result_t r;
    int          hits;
    int          slot;
    int          i;
    hits = 0;
    slot = -1;
    for (i = 0; i < bag_fill; i++) begin
      if (bag_vals[i] == val) begin
        hits++;
        if (slot < 0) slot = i;
      end
    end
    r.occ  = CNT_W'(hits);
    r.done = 1'b0;
    case (op)
      OP_INSERT: begin
        if (bag_fill < BAG_CAP) begin
          bag_vals[bag_fill] = val;
          bag_fill++;
          r.done = 1'b1;
        end
      end
      OP_REMOVE: begin
        // move the last entry into the freed slot
        if (slot >= 0) begin
          bag_vals[slot] = bag_vals[bag_fill-1];
          bag_fill--;
          r.done = 1'b1;
        end
      end
      OP_COUNT: begin
        r.done = 1'b1;
      end
      default: ;
    endcase
    r.stored = CNT_W'(bag_fill);
    return r;
  endfunction

  // one beat: random idle cycles with junk on the bus, then hold start until accepted
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic typed, input bag_result_t typed_res);
    bag_result_t res;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do begin
        op_i    <= OP_W'($urandom_range(3));
        value_i <= $urandom;
        @(posedge clk_i);
      end while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    op_i    <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // accepted at this edge
    res = bag_apply(op, val);
    n_by_op[op]++;
    if (op == OP_INSERT && !res.done) n_full_ins++;
    if (op == OP_REMOVE && !res.done) n_miss_rem++;
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result monitor: every strobe must match the oldest prediction
  always @(posedge clk_i) begin : result_check
    bag_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result occ %0d done %0d stored %0d", $time,
                 occurrences_o, done_res_o, stored_count_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if ({occurrences_o, done_res_o, stored_count_o} !== want) begin
          $display("%0t: mismatch expected occ %0d done %0d stored %0d, got occ %0d done %0d stored %0d",
                   $time, want.occ, want.done, want.stored,
                   occurrences_o, done_res_o, stored_count_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on a cycle count well above the slowest correct run
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
             pending_results.size());
    $display("bounded_multiset_store_top_test: errors");
    $finish;
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] pool [4];
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] val;
    int                 row;
    int                 blk;
    int                 k;
    int                 i;
    int                 mode;
    int                 r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    idle_pct = 45;
    for (row = 0; row < DIR_ROWS_N; row++) begin
      send_beat(DIR_ROWS[row].op, DIR_ROWS[row].value, DIR_ROWS[row].typed,
                DIR_ROWS[row].res);
    end
    drain_results();

    // random blocks of 50 beats
    for (blk = 0; blk < 40; blk++) begin
      // 45 percent is the chance of idling before a beat and of each further idle cycle
      idle_pct = (blk >= 16 && blk < 22) ? 0 : 45;
      // mode 0 leans to inserts, 1 to removes, 2 is balanced
      mode = $urandom_range(2);
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(3))
          0:       pool[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
          1:       pool[i] = $urandom_range(7);
          2:       pool[i] = $urandom;
          default: pool[i] = 32'hffff_ffff ^ $urandom_range(3);
        endcase
      end
      for (k = 0; k < 50; k++) begin
        r = $urandom_range(99);
        if (r < 4)                                  op = OP_NOP;
        else if (r < (mode == 0 ? 70 : mode == 1 ? 25 : 45)) op = OP_INSERT;
        else if (r < (mode == 0 ? 85 : mode == 1 ? 80 : 75)) op = OP_REMOVE;
        else                                        op = OP_COUNT;
        r = $urandom_range(99);
        if (op == OP_REMOVE && bag_fill > 0 && r < 60) val = bag_vals[$urandom_range(bag_fill-1)];
        else if (r < 70)                               val = pool[$urandom_range(3)];
        else if (r < 90)                               val = $urandom_range(15);
        else                                           val = $urandom;
        send_beat(op, val, 1'b0, '0);
      end
      if (blk % 5 == 4) drain_results();
    end

    // end of stimulus: wait for the last results, then let the bench run quiet
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("beats: %0d insert, %0d remove, %0d count, %0d unused op", n_by_op[OP_INSERT],
             n_by_op[OP_REMOVE], n_by_op[OP_COUNT], n_by_op[OP_NOP]);
    $display("inserts into a full table: %0d, removes of an absent value: %0d",
             n_full_ins, n_miss_rem);
    if (n_errors == 0) begin
      $display("bounded_multiset_store_top_test: clean");
    end else begin
      $display("bounded_multiset_store_top_test: errors");
    end
    $finish;
  end

endmodule
